// ===== design/pfr_pkg.sv =====
package pfr_pkg;

    localparam int NUM_PROCS_DEF      = 4;
    localparam int PAGES_PER_PROC_DEF = 64;
    localparam int FRAME_COUNT_DEF    = 512;
    localparam int OFFSET_BITS_DEF    = 6;

    localparam int STAMP_W       = 32;
    localparam int CFG_W         = 7;
    localparam int NUM_PAGE_REGS = 4;
    localparam int PADDR_W       = 5;
    localparam int PDATA_W       = 32;
    localparam int REG_IDX_W     = 3;

    localparam logic [CFG_W-1:0] FRAME_LIMIT_RST = 7'd10;
    localparam logic             POLICY_RST      = 1'b0;
    localparam logic [CFG_W-1:0] PAGES_RST       = 7'd0;

    typedef enum logic [2:0] {
        STATUS_HIT       = 3'd0,
        STATUS_NEW_FRAME = 3'd1,
        STATUS_REPLACED  = 3'd2,
        STATUS_SEGFAULT  = 3'd3,
        STATUS_NO_FRAME  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_EVAL,
        ENG_HIT,
        ENG_SCAN,
        ENG_COMMIT,
        ENG_EMIT
    } eng_state_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FRAME_LIMIT = 3'd0,
        REG_POLICY      = 3'd1,
        REG_PAGES_PROC0 = 3'd2,
        REG_PAGES_PROC1 = 3'd3,
        REG_PAGES_PROC2 = 3'd4,
        REG_PAGES_PROC3 = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic clear;
        logic sample;
        logic present;
    } scan_ctl_t;

endpackage

// ===== design/pfr_ram.sv =====
module pfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/pfr_scan.sv =====
module pfr_scan #(
    parameter int PAGE_W  = 6,
    parameter int FRAME_W = 9
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pfr_pkg::scan_ctl_t       ctl,
    input  logic [PAGE_W-1:0]        page,
    input  logic [pfr_pkg::STAMP_W-1:0] stamp,
    input  logic [FRAME_W-1:0]       frame,
    output logic                     found,
    output logic [PAGE_W-1:0]        victim_page,
    output logic [FRAME_W-1:0]       victim_frame
);

    logic                        found_reg, found_next;
    logic [pfr_pkg::STAMP_W-1:0] best_reg, best_next;
    logic [PAGE_W-1:0]           page_reg, page_next;
    logic [FRAME_W-1:0]          frame_reg, frame_next;
    logic                        take;

    // A strict compare keeps the lowest page number among equal stamps.
    assign take = ctl.sample && ctl.present && (!found_reg || (stamp < best_reg));

    always_comb
    begin
        found_next = found_reg;
        best_next  = best_reg;
        page_next  = page_reg;
        frame_next = frame_reg;
        if (ctl.clear)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next = 1'b1;
            best_next  = stamp;
            page_next  = page;
            frame_next = frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg  <= best_next;
        page_reg  <= page_next;
        frame_reg <= frame_next;
    end

    assign found        = found_reg;
    assign victim_page  = page_reg;
    assign victim_frame = frame_reg;

endmodule

// ===== design/pfr_core.sv =====
module pfr_core #(
    parameter int NUM_PROCS      = pfr_pkg::NUM_PROCS_DEF,
    parameter int PAGES_PER_PROC = pfr_pkg::PAGES_PER_PROC_DEF,
    parameter int FRAME_COUNT    = pfr_pkg::FRAME_COUNT_DEF,
    parameter int OFFSET_BITS    = pfr_pkg::OFFSET_BITS_DEF,
    localparam int PROC_W  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1,
    localparam int PAGE_W  = (PAGES_PER_PROC > 1) ? $clog2(PAGES_PER_PROC) : 1,
    localparam int FRAME_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1,
    localparam int RES_W   = $clog2(PAGES_PER_PROC + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pfr_pkg::CFG_W-1:0]     frame_limit,
    input  logic                          policy_select,
    input  logic [pfr_pkg::CFG_W-1:0]     pages_cfg [pfr_pkg::NUM_PAGE_REGS],
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [PROC_W-1:0]             proc_id,
    input  logic [PAGE_W-1:0]             page_num,
    input  logic [OFFSET_BITS-1:0]        page_offset,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    status,
    output logic [FRAME_W-1:0]            frame_num,
    output logic [OFFSET_BITS-1:0]        phys_offset,
    output logic                          evicted_valid,
    output logic [PAGE_W-1:0]             evicted_page,
    output logic [RES_W-1:0]              resident_count
);

    localparam int STAMP_W = pfr_pkg::STAMP_W;
    localparam int DEPTH   = NUM_PROCS * PAGES_PER_PROC;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ENTRY_W = FRAME_W + 2 * STAMP_W;
    localparam int NFF_W   = $clog2(FRAME_COUNT + 1);
    localparam int CNT_W   = $clog2(PAGES_PER_PROC + 1);
    localparam int LIM_W   = (RES_W > pfr_pkg::CFG_W) ? RES_W : pfr_pkg::CFG_W;

    pfr_pkg::eng_state_t state_reg, state_next;

    logic [PROC_W-1:0]      proc_reg, proc_next;
    logic [PAGE_W-1:0]      page_reg, page_next;
    logic [OFFSET_BITS-1:0] offs_reg, offs_next;

    logic [DEPTH-1:0]       present_reg, present_next;
    logic [RES_W-1:0]       res_reg [NUM_PROCS];
    logic [RES_W-1:0]       res_next [NUM_PROCS];
    logic [NFF_W-1:0]       nff_reg, nff_next;
    logic [STAMP_W-1:0]     timer_reg, timer_next;
    logic                   halted_reg, halted_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic                   samp_valid_reg, samp_valid_next;
    logic                   samp_present_reg, samp_present_next;
    logic [PAGE_W-1:0]      samp_page_reg, samp_page_next;

    pfr_pkg::status_t       rs_status_reg, rs_status_next;
    logic [FRAME_W-1:0]     rs_frame_reg, rs_frame_next;
    logic                   rs_ev_valid_reg, rs_ev_valid_next;
    logic [PAGE_W-1:0]      rs_ev_page_reg, rs_ev_page_next;
    logic [RES_W-1:0]       rs_res_reg, rs_res_next;

    logic                   out_valid_reg, out_valid_next;
    pfr_pkg::status_t       out_status_reg;
    logic [FRAME_W-1:0]     out_frame_reg;
    logic [OFFSET_BITS-1:0] out_offs_reg;
    logic                   out_ev_valid_reg;
    logic [PAGE_W-1:0]      out_ev_page_reg;
    logic [RES_W-1:0]       out_res_reg;
    logic                   out_load;

    logic                   ram_we, ram_re;
    logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;
    logic [FRAME_W-1:0]     rd_frame;
    logic [STAMP_W-1:0]     rd_load, rd_use;

    pfr_pkg::scan_ctl_t     scan_ctl;
    logic                   vic_found;
    logic [PAGE_W-1:0]      vic_page;
    logic [FRAME_W-1:0]     vic_frame;

    logic                      proc_ok;
    logic [pfr_pkg::CFG_W-1:0] pages_sel;
    logic [LIM_W-1:0]          limit_pages;
    logic [pfr_pkg::CFG_W-1:0] lim_eff;
    logic [RES_W-1:0]          res_cur;
    logic [ADDR_W-1:0]         base, idx, scan_addr, vic_addr;
    logic                      segv, has_room, nff_full;
    logic [STAMP_W-1:0]        timer_inc;

    assign rd_frame = ram_rdata[ENTRY_W-1 -: FRAME_W];
    assign rd_load  = ram_rdata[2*STAMP_W-1:STAMP_W];
    assign rd_use   = ram_rdata[STAMP_W-1:0];

    assign proc_ok = int'(proc_reg) < NUM_PROCS;

    always_comb
    begin
        pages_sel = '0;
        for (int i = 0; i < pfr_pkg::NUM_PAGE_REGS; i++)
        begin
            if (proc_ok && int'(proc_reg) == i)
            begin
                pages_sel = pages_cfg[i];
            end
        end
        res_cur = '0;
        for (int i = 0; i < NUM_PROCS; i++)
        begin
            if (int'(proc_reg) == i)
            begin
                res_cur = res_reg[i];
            end
        end
    end

    assign limit_pages = (LIM_W'(pages_sel) > LIM_W'(PAGES_PER_PROC))
                         ? LIM_W'(PAGES_PER_PROC) : LIM_W'(pages_sel);
    assign segv      = LIM_W'(page_reg) >= limit_pages;
    assign lim_eff   = (frame_limit == '0) ? pfr_pkg::CFG_W'(1) : frame_limit;
    assign has_room  = LIM_W'(res_cur) < LIM_W'(lim_eff);
    assign nff_full  = nff_reg >= NFF_W'(FRAME_COUNT);
    assign timer_inc = timer_reg + STAMP_W'(1);

    assign base      = ADDR_W'(ADDR_W'(proc_reg) * ADDR_W'(PAGES_PER_PROC));
    assign idx       = base + ADDR_W'(page_reg);
    assign scan_addr = base + ADDR_W'(cnt_reg[PAGE_W-1:0]);
    assign vic_addr  = base + ADDR_W'(vic_page);

    assign out_load  = (state_reg == pfr_pkg::ENG_EMIT) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfr_pkg::ENG_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        in_stall          = 1'b1;
        proc_next         = proc_reg;
        page_next         = page_reg;
        offs_next         = offs_reg;
        present_next      = present_reg;
        res_next          = res_reg;
        nff_next          = nff_reg;
        timer_next        = timer_reg;
        halted_next       = halted_reg;
        cnt_next          = cnt_reg;
        samp_valid_next   = 1'b0;
        samp_present_next = samp_present_reg;
        samp_page_next    = samp_page_reg;
        rs_status_next    = rs_status_reg;
        rs_frame_next     = rs_frame_reg;
        rs_ev_valid_next  = rs_ev_valid_reg;
        rs_ev_page_next   = rs_ev_page_reg;
        rs_res_next       = rs_res_reg;
        ram_we            = 1'b0;
        ram_waddr         = idx;
        ram_wdata         = {rd_frame, rd_load, timer_reg};
        ram_re            = 1'b0;
        ram_raddr         = idx;
        scan_ctl          = '0;

        unique case (state_reg)
            pfr_pkg::ENG_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    proc_next  = proc_id;
                    page_next  = page_num;
                    offs_next  = page_offset;
                    state_next = pfr_pkg::ENG_EVAL;
                end
            end
            pfr_pkg::ENG_EVAL:
            begin
                rs_frame_next    = '0;
                rs_ev_valid_next = 1'b0;
                rs_ev_page_next  = '0;
                rs_res_next      = res_cur;
                state_next       = pfr_pkg::ENG_EMIT;
                if (halted_reg)
                begin
                    rs_status_next = pfr_pkg::STATUS_NO_FRAME;
                end
                else
                begin
                    timer_next = timer_inc;
                    if (segv)
                    begin
                        rs_status_next = pfr_pkg::STATUS_SEGFAULT;
                        halted_next    = 1'b1;
                    end
                    else if (present_reg[idx])
                    begin
                        ram_re     = 1'b1;
                        state_next = pfr_pkg::ENG_HIT;
                    end
                    else if (has_room)
                    begin
                        if (nff_full)
                        begin
                            rs_status_next = pfr_pkg::STATUS_NO_FRAME;
                        end
                        else
                        begin
                            ram_we            = 1'b1;
                            ram_wdata         = {nff_reg[FRAME_W-1:0], timer_inc, timer_inc};
                            present_next[idx] = 1'b1;
                            nff_next          = nff_reg + NFF_W'(1);
                            for (int i = 0; i < NUM_PROCS; i++)
                            begin
                                if (int'(proc_reg) == i)
                                begin
                                    res_next[i] = res_reg[i] + RES_W'(1);
                                end
                            end
                            rs_status_next = pfr_pkg::STATUS_NEW_FRAME;
                            rs_frame_next  = nff_reg[FRAME_W-1:0];
                            rs_res_next    = res_cur + RES_W'(1);
                        end
                    end
                    else
                    begin
                        cnt_next       = '0;
                        scan_ctl.clear = 1'b1;
                        state_next     = pfr_pkg::ENG_SCAN;
                    end
                end
            end
            pfr_pkg::ENG_HIT:
            begin
                ram_we         = 1'b1;
                ram_wdata      = {rd_frame, rd_load, timer_reg};
                rs_status_next = pfr_pkg::STATUS_HIT;
                rs_frame_next  = rd_frame;
                state_next     = pfr_pkg::ENG_EMIT;
            end
            pfr_pkg::ENG_SCAN:
            begin
                if (int'(cnt_reg) < PAGES_PER_PROC)
                begin
                    ram_re            = 1'b1;
                    ram_raddr         = scan_addr;
                    samp_valid_next   = 1'b1;
                    samp_present_next = present_reg[scan_addr];
                    samp_page_next    = cnt_reg[PAGE_W-1:0];
                    cnt_next          = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = pfr_pkg::ENG_COMMIT;
                end
            end
            pfr_pkg::ENG_COMMIT:
            begin
                state_next = pfr_pkg::ENG_EMIT;
                if (vic_found)
                begin
                    present_next[vic_addr] = 1'b0;
                    present_next[idx]      = 1'b1;
                    ram_we                 = 1'b1;
                    ram_wdata              = {vic_frame, timer_reg, timer_reg};
                    rs_status_next         = pfr_pkg::STATUS_REPLACED;
                    rs_frame_next          = vic_frame;
                    rs_ev_valid_next       = 1'b1;
                    rs_ev_page_next        = vic_page;
                end
                else
                begin
                    rs_status_next = pfr_pkg::STATUS_NO_FRAME;
                end
            end
            pfr_pkg::ENG_EMIT:
            begin
                if (out_load)
                begin
                    state_next = pfr_pkg::ENG_IDLE;
                end
            end
            default:
            begin
                state_next = pfr_pkg::ENG_IDLE;
            end
        endcase

        scan_ctl.sample  = samp_valid_reg;
        scan_ctl.present = samp_present_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg    <= '0;
            for (int i = 0; i < NUM_PROCS; i++)
            begin
                res_reg[i] <= '0;
            end
            nff_reg        <= '0;
            timer_reg      <= '0;
            halted_reg     <= 1'b0;
            samp_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            present_reg    <= present_next;
            res_reg        <= res_next;
            nff_reg        <= nff_next;
            timer_reg      <= timer_next;
            halted_reg     <= halted_next;
            samp_valid_reg <= samp_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_reg         <= proc_next;
        page_reg         <= page_next;
        offs_reg         <= offs_next;
        cnt_reg          <= cnt_next;
        samp_present_reg <= samp_present_next;
        samp_page_reg    <= samp_page_next;
        rs_status_reg    <= rs_status_next;
        rs_frame_reg     <= rs_frame_next;
        rs_ev_valid_reg  <= rs_ev_valid_next;
        rs_ev_page_reg   <= rs_ev_page_next;
        rs_res_reg       <= rs_res_next;
        if (out_load)
        begin
            out_status_reg   <= rs_status_reg;
            out_frame_reg    <= rs_frame_reg;
            out_offs_reg     <= offs_reg;
            out_ev_valid_reg <= rs_ev_valid_reg;
            out_ev_page_reg  <= rs_ev_page_reg;
            out_res_reg      <= rs_res_reg;
        end
    end

    pfr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pfr_scan #(
        .PAGE_W  (PAGE_W),
        .FRAME_W (FRAME_W)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (scan_ctl),
        .page         (samp_page_reg),
        .stamp        (policy_select ? rd_use : rd_load),
        .frame        (rd_frame),
        .found        (vic_found),
        .victim_page  (vic_page),
        .victim_frame (vic_frame)
    );

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign frame_num      = out_frame_reg;
    assign phys_offset    = out_offs_reg;
    assign evicted_valid  = out_ev_valid_reg;
    assign evicted_page   = out_ev_page_reg;
    assign resident_count = out_res_reg;

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag dropped without reset");

    a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nff_reg <= NFF_W'(FRAME_COUNT))
        else $error("free frame counter ran past the frame count");

    a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("entry memory read and written in one cycle");

    a_victim_present: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pfr_pkg::ENG_COMMIT && vic_found) |-> present_reg[vic_addr])
        else $error("chosen victim is not resident");

endmodule

// ===== design/page_fault_replacement_unit.sv =====
// Channel   Direction  Handshake          Beat
// access    in         in_valid/in_stall  proc_id, page_num, page_offset
// result    out        out_valid/out_stall status, frame_num, phys_offset, evicted_valid,
//                                         evicted_page, resident_count
// config    in         APB write          frame_limit, policy_select, pages_proc0..3
//
// One access is in flight at a time; the next is taken once the result is in the output register.
// A hit passes through the EVAL, HIT and EMIT states; a fault served from a free frame
// through EVAL and EMIT. A replacement adds SCAN and COMMIT, the victim scan reading one
// entry per cycle through the entry memory read port.
// Reset clears the resident bits, counters, timer and halt flag at once; no clearing pass.
// A stalled result holds in the output register while the next access is accepted.
module page_fault_replacement_unit #(
    parameter int NUM_PROCS      = pfr_pkg::NUM_PROCS_DEF,
    parameter int PAGES_PER_PROC = pfr_pkg::PAGES_PER_PROC_DEF,
    parameter int FRAME_COUNT    = pfr_pkg::FRAME_COUNT_DEF,
    parameter int OFFSET_BITS    = pfr_pkg::OFFSET_BITS_DEF,
    localparam int PROC_W  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1,
    localparam int PAGE_W  = (PAGES_PER_PROC > 1) ? $clog2(PAGES_PER_PROC) : 1,
    localparam int FRAME_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1,
    localparam int RES_W   = $clog2(PAGES_PER_PROC + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pfr_pkg::PADDR_W-1:0]   paddr,
    input  logic [pfr_pkg::PDATA_W-1:0]   pwdata,
    output logic [pfr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [PROC_W-1:0]             proc_id,
    input  logic [PAGE_W-1:0]             page_num,
    input  logic [OFFSET_BITS-1:0]        page_offset,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    status,
    output logic [FRAME_W-1:0]            frame_num,
    output logic [OFFSET_BITS-1:0]        phys_offset,
    output logic                          evicted_valid,
    output logic [PAGE_W-1:0]             evicted_page,
    output logic [RES_W-1:0]              resident_count
);

    logic [pfr_pkg::CFG_W-1:0] frame_limit_reg, frame_limit_next;
    logic                      policy_reg, policy_next;
    logic [pfr_pkg::CFG_W-1:0] pages_reg [pfr_pkg::NUM_PAGE_REGS];
    logic [pfr_pkg::CFG_W-1:0] pages_next [pfr_pkg::NUM_PAGE_REGS];
    logic                      wr_en;
    pfr_pkg::reg_idx_t         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = pfr_pkg::reg_idx_t'(paddr[pfr_pkg::PADDR_W-1:2]);

    always_comb
    begin
        frame_limit_next = frame_limit_reg;
        policy_next      = policy_reg;
        pages_next       = pages_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                pfr_pkg::REG_FRAME_LIMIT: frame_limit_next = pwdata[pfr_pkg::CFG_W-1:0];
                pfr_pkg::REG_POLICY:      policy_next      = pwdata[0];
                pfr_pkg::REG_PAGES_PROC0: pages_next[0]    = pwdata[pfr_pkg::CFG_W-1:0];
                pfr_pkg::REG_PAGES_PROC1: pages_next[1]    = pwdata[pfr_pkg::CFG_W-1:0];
                pfr_pkg::REG_PAGES_PROC2: pages_next[2]    = pwdata[pfr_pkg::CFG_W-1:0];
                pfr_pkg::REG_PAGES_PROC3: pages_next[3]    = pwdata[pfr_pkg::CFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            pfr_pkg::REG_FRAME_LIMIT: prdata = pfr_pkg::PDATA_W'(frame_limit_reg);
            pfr_pkg::REG_POLICY:      prdata = pfr_pkg::PDATA_W'(policy_reg);
            pfr_pkg::REG_PAGES_PROC0: prdata = pfr_pkg::PDATA_W'(pages_reg[0]);
            pfr_pkg::REG_PAGES_PROC1: prdata = pfr_pkg::PDATA_W'(pages_reg[1]);
            pfr_pkg::REG_PAGES_PROC2: prdata = pfr_pkg::PDATA_W'(pages_reg[2]);
            pfr_pkg::REG_PAGES_PROC3: prdata = pfr_pkg::PDATA_W'(pages_reg[3]);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_limit_reg <= pfr_pkg::FRAME_LIMIT_RST;
            policy_reg      <= pfr_pkg::POLICY_RST;
            for (int i = 0; i < pfr_pkg::NUM_PAGE_REGS; i++)
            begin
                pages_reg[i] <= pfr_pkg::PAGES_RST;
            end
        end
        else
        begin
            frame_limit_reg <= frame_limit_next;
            policy_reg      <= policy_next;
            pages_reg       <= pages_next;
        end
    end

    pfr_core #(
        .NUM_PROCS      (NUM_PROCS),
        .PAGES_PER_PROC (PAGES_PER_PROC),
        .FRAME_COUNT    (FRAME_COUNT),
        .OFFSET_BITS    (OFFSET_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_limit    (frame_limit_reg),
        .policy_select  (policy_reg),
        .pages_cfg      (pages_reg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .proc_id        (proc_id),
        .page_num       (page_num),
        .page_offset    (page_offset),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .frame_num      (frame_num),
        .phys_offset    (phys_offset),
        .evicted_valid  (evicted_valid),
        .evicted_page   (evicted_page),
        .resident_count (resident_count)
    );

endmodule
